// ----- src/necird_pkg.sv -----
// Package: shared types, register indexes and helpers for the NEC IR edge decoder.
`default_nettype none
package necird_pkg;

	localparam int unsigned CapW   = 16;
	localparam int unsigned UsW    = 20;
	localparam int unsigned NumReg = 8;
	localparam int unsigned IdxW   = 3;
	localparam int unsigned WordW  = 32;
	localparam int unsigned CntW   = 6;

	localparam logic [CntW-1:0] FrameBits = 6'd32;
	localparam logic [UsW-1:0]  EndGapUs  = 20'd30000;

	// register indexes
	localparam logic [IdxW-1:0] REG_LEADER_MARK_MIN  = 3'd0;
	localparam logic [IdxW-1:0] REG_LEADER_MARK_MAX  = 3'd1;
	localparam logic [IdxW-1:0] REG_LEADER_SPACE_MIN = 3'd2;
	localparam logic [IdxW-1:0] REG_LEADER_SPACE_MAX = 3'd3;
	localparam logic [IdxW-1:0] REG_ZERO_SPACE_MIN   = 3'd4;
	localparam logic [IdxW-1:0] REG_ZERO_SPACE_MAX   = 3'd5;
	localparam logic [IdxW-1:0] REG_ONE_SPACE_MIN    = 3'd6;
	localparam logic [IdxW-1:0] REG_ONE_SPACE_MAX    = 3'd7;

	typedef logic [NumReg-1:0][UsW-1:0] cfg_bank_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_FRAME = 2'd1,
		EV_END   = 2'd2
	} frame_event_t;

	typedef enum logic [2:0] {
		EDGE_FIRST   = 3'b001,
		EDGE_RISING  = 3'b010,
		EDGE_FALLING = 3'b100
	} edge_phase_t;

	typedef enum logic [2:0] {
		FRM_IDLE   = 3'b001,
		FRM_MARK   = 3'b010,
		FRM_DECODE = 3'b100
	} frame_phase_t;

	typedef struct packed {
		logic             arm_rising;
		frame_event_t     frame_event;
		logic [WordW-1:0] frame_word;
		logic [7:0]       command_byte;
	} result_t;

	// exclusive window check
	function automatic logic in_window(input logic [UsW-1:0] w,
		input logic [UsW-1:0] lo, input logic [UsW-1:0] hi);
		return (w > lo) && (w < hi);
	endfunction

endpackage
`default_nettype wire

// ----- src/necird_in_if.sv -----
// Interface: input capture channel.
`default_nettype none
interface necird_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] capture_ticks;

	modport source (output valid, output capture_ticks, input ready);
	modport sink (input valid, input capture_ticks, output ready);
endinterface
`default_nettype wire

// ----- src/necird_out_if.sv -----
// Interface: result channel.
`default_nettype none
interface necird_out_if;
	logic        valid;
	logic        ready;
	logic        arm_rising;
	logic [1:0]  frame_event;
	logic [31:0] frame_word;
	logic [7:0]  command_byte;

	modport source (output valid, output arm_rising, output frame_event,
		output frame_word, output command_byte, input ready);
	modport sink (input valid, input arm_rising, input frame_event,
		input frame_word, input command_byte, output ready);
endinterface
`default_nettype wire

// ----- src/nec_ir_edge_decoder_top.sv -----
// A capture accepted on the input moves through the stage-1 and result registers;
// throughput is one capture per cycle unless the output stalls. The decode is one
// short pass from stage 1 to the result register, state updating as the stage moves.
// Reset (arst_n low, asynchronous): both stages empty, frame state idle, first edge
// awaited, timing bounds back to their defaults.
// Top level: NEC IR edge decoder with input stage, core and result register.
`default_nettype none
module nec_ir_edge_decoder_top
	import necird_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	necird_in_if.sink            in_ch,
	necird_out_if.source         out_ch,
	input  wire logic            cfg_we,
	input  wire logic [IdxW-1:0] cfg_index,
	input  wire logic [UsW-1:0]  cfg_wdata
);

	cfg_bank_t       bank;
	result_t         res;
	result_t         res_s2;
	logic            valid_s1, valid_s2;
	logic [CapW-1:0] cap_s1;
	logic            advance;
	logic            take_in;

	necird_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.bank      (bank)
	);

	// the stage-1 beat moves into the result register when that one is free
	// or is being drained this cycle; the core state steps with it
	assign advance      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign take_in      = in_ch.valid && in_ch.ready;

	necird_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cap    (cap_s1),
		.bank   (bank),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (take_in) begin
			cap_s1 <= in_ch.capture_ticks;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.arm_rising   = res_s2.arm_rising;
	assign out_ch.frame_event  = res_s2.frame_event;
	assign out_ch.frame_word   = res_s2.frame_word;
	assign out_ch.command_byte = res_s2.command_byte;

`ifndef ASSERT_OFF
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(cap_s1))
		else $error("stage 1 beat lost while stalled");
	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result register not filled");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ch.ready |-> !advance)
		else $error("result overwritten before taken");
`endif

endmodule
`default_nettype wire

// ----- src/necird_cfg.sv -----
// Configuration register bank: eight 20-bit timing bounds.
`default_nettype none
module necird_cfg
	import necird_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [IdxW-1:0] cfg_index,
	input  wire logic [UsW-1:0]  cfg_wdata,
	output cfg_bank_t            bank
);

	cfg_bank_t bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q[REG_LEADER_MARK_MIN]  <= 20'd8000;
			bank_q[REG_LEADER_MARK_MAX]  <= 20'd10000;
			bank_q[REG_LEADER_SPACE_MIN] <= 20'd4000;
			bank_q[REG_LEADER_SPACE_MAX] <= 20'd5000;
			bank_q[REG_ZERO_SPACE_MIN]   <= 20'd500;
			bank_q[REG_ZERO_SPACE_MAX]   <= 20'd800;
			bank_q[REG_ONE_SPACE_MIN]    <= 20'd1500;
			bank_q[REG_ONE_SPACE_MAX]    <= 20'd2000;
		end else if (cfg_we) begin
			bank_q[cfg_index] <= cfg_wdata;
		end
	end

	assign bank = bank_q;

endmodule
`default_nettype wire

// ----- src/necird_core.sv -----
// Decoder core: per-edge width measurement, frame state and bit shifter.
`default_nettype none
module necird_core
	import necird_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [CapW-1:0] cap,
	input  wire cfg_bank_t       bank,
	output result_t              res
);

	edge_phase_t      edge_q, edge_d;
	frame_phase_t     frame_q, frame_d;
	logic [CapW-1:0]  last_cap_q;
	logic [CntW-1:0]  bit_cnt_q, bit_cnt_d;
	logic [WordW-1:0] shift_q, shift_d;
	logic [7:0]       cmd_q, cmd_d;

	logic [CapW-1:0]  diff;
	logic [UsW-1:0]   width_us;
	logic [WordW-1:0] shifted;
	logic             is_zero, is_one;

	// width = ticks * 10, as two shifted adds
	assign diff     = cap - last_cap_q;
	assign width_us = {1'b0, diff, 3'b000} + {3'b000, diff, 1'b0};
	assign is_zero  = in_window(width_us, bank[REG_ZERO_SPACE_MIN], bank[REG_ZERO_SPACE_MAX]);
	assign is_one   = in_window(width_us, bank[REG_ONE_SPACE_MIN], bank[REG_ONE_SPACE_MAX]);

	always_comb begin
		edge_d    = edge_q;
		frame_d   = frame_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		cmd_d     = cmd_q;
		shifted   = shift_q;
		res.arm_rising  = 1'b0;
		res.frame_event = EV_NONE;
		case (edge_q)
			EDGE_FIRST: begin
				edge_d         = EDGE_RISING;
				res.arm_rising = 1'b1;
			end
			EDGE_RISING: begin
				// end of low mark
				if (frame_q == FRM_IDLE && in_window(width_us,
					bank[REG_LEADER_MARK_MIN], bank[REG_LEADER_MARK_MAX])) begin
					frame_d = FRM_MARK;
				end
				edge_d = EDGE_FALLING;
			end
			default: begin
				// falling edge, end of high space
				if (frame_q == FRM_MARK && in_window(width_us,
					bank[REG_LEADER_SPACE_MIN], bank[REG_LEADER_SPACE_MAX])) begin
					frame_d = FRM_DECODE;
				end else if (frame_q == FRM_DECODE && bit_cnt_q < FrameBits) begin
					if (is_zero) begin
						shifted = {shift_q[WordW-2:0], 1'b0};
					end else if (is_one) begin
						shifted = {shift_q[WordW-2:0], 1'b1};
					end
					shift_d   = shifted;
					bit_cnt_d = bit_cnt_q + 6'd1;
					if (bit_cnt_d == FrameBits) begin
						cmd_d = shifted[15:8];
						if (shifted[31:24] == ~shifted[23:16] &&
							shifted[15:8] == ~shifted[7:0]) begin
							res.frame_event = EV_FRAME;
						end
					end
				end else if (bit_cnt_q == FrameBits && width_us > EndGapUs) begin
					res.frame_event = EV_END;
					frame_d         = FRM_IDLE;
					bit_cnt_d       = '0;
				end
				edge_d         = EDGE_RISING;
				res.arm_rising = 1'b1;
			end
		endcase
		res.frame_word   = shift_d;
		res.command_byte = cmd_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q     <= EDGE_FIRST;
			frame_q    <= FRM_IDLE;
			last_cap_q <= '0;
			bit_cnt_q  <= '0;
			shift_q    <= '0;
			cmd_q      <= '0;
		end else if (step) begin
			edge_q     <= edge_d;
			frame_q    <= frame_d;
			last_cap_q <= cap;
			bit_cnt_q  <= bit_cnt_d;
			shift_q    <= shift_d;
			cmd_q      <= cmd_d;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q <= FrameBits)
		else $error("bit count past frame length");
	a_cnt_only_decode: assert property (@(posedge clk) disable iff (!arst_n)
		frame_q != FRM_DECODE |-> bit_cnt_q == '0)
		else $error("bits counted outside decoding");
	a_no_first_again: assert property (@(posedge clk) disable iff (!arst_n)
		edge_q != EDGE_FIRST |=> edge_q != EDGE_FIRST)
		else $error("edge phase returned to first edge");
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.frame_event == EV_END |=> frame_q == FRM_IDLE && bit_cnt_q == '0)
		else $error("end gap did not rearm");
`endif

endmodule
`default_nettype wire
